@@ hdl/utf8wn_pkg.sv @@
package utf8wn_pkg;

  // Default depth of the look-ahead window.
  localparam int PENDING_DEPTH_DEF = 16;
  // Depth of the queue between the front end and the engine.
  localparam int QUEUE_DEPTH = 2;
  // Depth of the store for held-back spaces and line feeds.
  localparam int HOLD_DEPTH = 3;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // One queued request: a text byte and its end-of-message mark.
  typedef struct packed {
    logic       is_final;
    logic [7:0] text_byte;
  } q_item_t;

  // Result of the look-ahead usability check at one window position.
  typedef struct packed {
    logic       ok;
    logic [1:0] len;
  } usab_t;

  function automatic logic is_ctrl(input logic [7:0] b);
    return (b < 8'h20 && b != CH_LF) || b == CH_DEL;
  endfunction

  function automatic logic [1:0] lead_need(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd1;
    if (b == 8'hC2 || b == 8'hCD) n = 2'd2;
    if (b == 8'hE1 || b == 8'hE2 || b == 8'hE3 || b == 8'hEF) n = 2'd3;
    return n;
  endfunction

  // Invisible characters: returns their length in bytes, or zero.
  function automatic logic [1:0] m_inv(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [1:0] len);
    logic [1:0] r;
    r = 2'd0;
    if (len > 2'd1 && a == 8'hCD && b == 8'h8F) r = 2'd2;
    else if (len > 2'd2 && ((a == 8'hE2 && b == 8'h80 && c >= 8'h8B && c <= 8'h8D) ||
                            (a == 8'hE2 && b == 8'h81 && c == 8'hA0) ||
                            (a == 8'hEF && b == 8'hBB && c == 8'hBF))) r = 2'd3;
    return r;
  endfunction

  // Space characters.
  function automatic logic [1:0] m_sp(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [1:0] len);
    logic [1:0] r;
    r = 2'd0;
    if (len > 2'd0 && a == CH_SPACE) r = 2'd1;
    else if (len > 2'd1 && a == 8'hC2 && b == 8'hA0) r = 2'd2;
    else if (len > 2'd2 && ((a == 8'hE1 && b == 8'h9A && c == 8'h80) ||
                            (a == 8'hE2 && b == 8'h80 && c >= 8'h80 && c <= 8'h8A) ||
                            (a == 8'hE2 && b == 8'h80 && c == 8'hAF) ||
                            (a == 8'hE2 && b == 8'h81 && c == 8'h9F) ||
                            (a == 8'hE3 && b == 8'h80 && c >= 8'h80))) r = 2'd3;
    return r;
  endfunction

  // Newline characters.
  function automatic logic [1:0] m_nl(input logic [7:0] a, input logic [7:0] b,
                                      input logic [7:0] c, input logic [1:0] len);
    logic [1:0] r;
    r = 2'd0;
    if (len > 2'd0 && a == CH_LF) r = 2'd1;
    else if (len > 2'd1 && a == 8'hC2 && b == 8'h85) r = 2'd2;
    else if (len > 2'd2 && a == 8'hE2 && b == 8'h80 && (c == 8'hA8 || c == 8'hA9))
      r = 2'd3;
    return r;
  endfunction

endpackage

@@ hdl/utf8wn_front.sv @@
module utf8wn_front
  import utf8wn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tlast,
  output logic       q_valid,
  input  logic       q_ready,
  output q_item_t    q_item
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  q_item_t        mem_r [QUEUE_DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           push, pop;

  assign in_tready = cnt_r != (AW+1)'(QUEUE_DEPTH);
  assign q_valid   = cnt_r != '0;
  assign q_item    = mem_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  // Request storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{is_final: in_tlast, text_byte: in_tdata};
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule

@@ hdl/utf8wn_engine.sv @@
module utf8wn_engine
  import utf8wn_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_ready,
  input  q_item_t    q_item,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic       out_tuser
);

  localparam int IW = $clog2(PENDING_DEPTH);
  localparam int CW = $clog2(PENDING_DEPTH + 1);
  localparam int PW = CW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_JUDGE = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  localparam logic MODE_INV = 1'b0;
  localparam logic MODE_SP  = 1'b1;

  // Window and message state.
  logic [7:0]    pend_r [PENDING_DEPTH];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    seq_r [HOLD_DEPTH];
  logic [1:0]    held_r, held_nxt;
  logic [7:0]    tail_r, tail_nxt;
  logic          tail_v_r, tail_v_nxt;
  logic [7:0]    rs0_r, rs0_nxt, rs1_r, rs1_nxt;
  logic [1:0]    em_r, em_nxt;
  logic [1:0]    pass_r, pass_nxt;
  logic          ovf_r, ovf_nxt;
  logic          at_end_r, at_end_nxt;

  // Sequencer state.
  logic [2:0]    st_r, st_nxt;
  logic          post_r, post_nxt;
  logic          fin_r, fin_nxt;
  logic [7:0]    cur_b_r, cur_b_nxt;
  logic          mode_r, mode_nxt;
  logic [1:0]    x_r, x_nxt;
  logic [PW-1:0] j_r, j_nxt;
  logic [7:0]    act_b_r, act_b_nxt;
  logic          act_trim_r, act_trim_nxt;
  logic [1:0]    fidx_r, fidx_nxt;

  // Output register.
  logic          out_v_r, out_v_nxt;
  logic [7:0]    out_b_r, out_b_nxt;
  logic          out_l_r, out_l_nxt;
  logic          out_u_r, out_u_nxt;

  // Window update controls.
  logic [2:0]    cons_k;
  logic          app;
  logic [7:0]    app_b;
  logic          seq_we;
  logic [1:0]    seq_wa;
  logic          slot_free;

  function automatic logic [7:0] win(input logic [PW-1:0] i);
    return (i < PW'(cnt_r)) ? pend_r[i[IW-1:0]] : 8'h00;
  endfunction

  function automatic usab_t usable(input logic [PW-1:0] p);
    logic [PW-1:0] avail;
    usab_t u;
    avail = (PW'(cnt_r) > p) ? PW'(cnt_r) - p : '0;
    u.len = (avail >= PW'(3)) ? 2'd3 : avail[1:0];
    u.ok  = at_end_r || (avail != '0 && avail >= PW'(lead_need(win(p))));
    return u;
  endfunction

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_b_r;
  assign out_tlast  = out_l_r;
  assign out_tuser  = out_u_r;
  assign slot_free  = !out_v_r || out_tready;
  assign q_ready    = st_r == S_IDLE;

  // Sequencer: one judgement, scan step or output per cycle while the output is not stalled.
  always_comb begin
    usab_t      u0, uo, ux;
    logic [1:0] x0, s0, n0, so, no, yx;
    logic       fail, nflush;
    logic [1:0] heff;

    st_nxt = st_r;   post_nxt = post_r; fin_nxt = fin_r; cur_b_nxt = cur_b_r;
    mode_nxt = mode_r; x_nxt = x_r; j_nxt = j_r;
    act_b_nxt = act_b_r; act_trim_nxt = act_trim_r; fidx_nxt = fidx_r;
    held_nxt = held_r; tail_nxt = tail_r; tail_v_nxt = tail_v_r;
    rs0_nxt = rs0_r; rs1_nxt = rs1_r; em_nxt = em_r; pass_nxt = pass_r;
    ovf_nxt = ovf_r; at_end_nxt = at_end_r;
    out_v_nxt = out_v_r && !out_tready;
    out_b_nxt = out_b_r; out_l_nxt = out_l_r; out_u_nxt = out_u_r;
    cons_k = 3'd0; app = 1'b0; app_b = cur_b_r;
    seq_we = 1'b0; seq_wa = held_r;
    fail = 1'b0; nflush = 1'b0; heff = held_r;

    u0 = usable(PW'(0));
    x0 = m_inv(win(PW'(0)), win(PW'(1)), win(PW'(2)), u0.len);
    s0 = m_sp(win(PW'(0)), win(PW'(1)), win(PW'(2)), u0.len);
    n0 = m_nl(win(PW'(0)), win(PW'(1)), win(PW'(2)), u0.len);
    uo = usable(j_r);
    so = m_sp(win(j_r), win(j_r + PW'(1)), win(j_r + PW'(2)), uo.len);
    no = m_nl(win(j_r), win(j_r + PW'(1)), win(j_r + PW'(2)), uo.len);
    ux = usable(PW'(x_r));
    yx = m_inv(win(PW'(x_r)), win(PW'(x_r) + PW'(1)), win(PW'(x_r) + PW'(2)), ux.len);

    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          cur_b_nxt = q_item.text_byte;
          fin_nxt   = q_item.is_final;
          st_nxt    = S_JUDGE;
          if (cnt_r == CW'(PENDING_DEPTH)) begin
            post_nxt   = 1'b0;
            at_end_nxt = 1'b0;
          end else begin
            app        = 1'b1;
            app_b      = q_item.text_byte;
            at_end_nxt = q_item.is_final;
            post_nxt   = 1'b1;
          end
        end
      end
      S_JUDGE: begin
        if (cnt_r == '0) begin
          fail = 1'b1;
        end else if (pass_r != 2'd0) begin
          pass_nxt = pass_r - 1'b1;
          act_b_nxt = pend_r[0]; act_trim_nxt = 1'b0; fidx_nxt = 2'd0;
          cons_k = 3'd1; st_nxt = S_EMIT;
        end else if (!u0.ok) begin
          fail = 1'b1;
        end else if (x0 != 2'd0) begin
          mode_nxt = MODE_INV; x_nxt = x0; j_nxt = PW'(x0); st_nxt = S_SCAN;
        end else if (s0 != 2'd0) begin
          if (em_r == 2'd0 || rs0_r == CH_SPACE || rs0_r == CH_LF) begin
            cons_k = {1'b0, s0};
          end else begin
            mode_nxt = MODE_SP; x_nxt = s0; j_nxt = PW'(s0); st_nxt = S_SCAN;
          end
        end else if (n0 != 2'd0) begin
          cons_k = {1'b0, n0};
          if (!(em_r != 2'd2 || (rs0_r == CH_LF && rs1_r == CH_LF))) begin
            act_b_nxt = CH_LF; act_trim_nxt = 1'b1; fidx_nxt = 2'd0; st_nxt = S_EMIT;
          end
        end else begin
          act_b_nxt = pend_r[0]; act_trim_nxt = 1'b0; fidx_nxt = 2'd0;
          cons_k = 3'd1; st_nxt = S_EMIT;
        end
      end
      S_SCAN: begin
        // Skip control bytes to reach the next visible character.
        if (j_r < PW'(cnt_r) && is_ctrl(win(j_r))) begin
          j_nxt = j_r + PW'(1);
        end else if (j_r >= PW'(cnt_r) && !at_end_r) begin
          fail = 1'b1;
        end else if (!uo.ok) begin
          fail = 1'b1;
        end else if (mode_r == MODE_SP) begin
          cons_k = {1'b0, x_r};
          st_nxt = S_JUDGE;
          if (no == 2'd0) begin
            act_b_nxt = CH_SPACE; act_trim_nxt = 1'b1; fidx_nxt = 2'd0; st_nxt = S_EMIT;
          end
        end else if (so != 2'd0 || no != 2'd0) begin
          cons_k = {1'b0, x_r}; st_nxt = S_JUDGE;
        end else if (!ux.ok) begin
          fail = 1'b1;
        end else if (yx != 2'd0) begin
          cons_k = {1'b0, x_r} + {1'b0, yx}; st_nxt = S_JUDGE;
        end else begin
          pass_nxt = x_r - 1'b1;
          act_b_nxt = pend_r[0]; act_trim_nxt = 1'b0; fidx_nxt = 2'd0;
          cons_k = 3'd1; st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        nflush = !act_trim_r || held_r == 2'(HOLD_DEPTH);
        if (nflush && (tail_v_r || fidx_r < held_r)) begin
          // Flush the tail byte, then the held whitespace, one byte a cycle while the output slot is free.
          if (slot_free) begin
            out_v_nxt = 1'b1; out_l_nxt = 1'b0; out_u_nxt = ovf_r;
            if (tail_v_r) begin
              out_b_nxt = tail_r; tail_v_nxt = 1'b0;
            end else begin
              out_b_nxt = seq_r[fidx_r]; fidx_nxt = fidx_r + 1'b1;
            end
          end
        end else begin
          if (nflush) heff = 2'd0;
          fidx_nxt = 2'd0;
          if (act_trim_r) begin
            seq_we = 1'b1; seq_wa = heff; held_nxt = heff + 1'b1;
          end else begin
            held_nxt = heff; tail_nxt = act_b_r; tail_v_nxt = 1'b1;
          end
          if (em_r != 2'd2) em_nxt = em_r + 1'b1;
          if (!is_ctrl(act_b_r)) begin
            rs1_nxt = rs0_r; rs0_nxt = act_b_r;
          end
          st_nxt = S_JUDGE;
        end
      end
      S_FINAL: begin
        if (!tail_v_r || slot_free) begin
          if (tail_v_r) begin
            out_v_nxt = 1'b1; out_b_nxt = tail_r; out_l_nxt = 1'b1; out_u_nxt = ovf_r;
          end
          held_nxt = 2'd0; tail_v_nxt = 1'b0; rs0_nxt = 8'h00; rs1_nxt = 8'h00;
          em_nxt = 2'd0; pass_nxt = 2'd0; ovf_nxt = 1'b0; at_end_nxt = 1'b0;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    // No further progress: append the new byte, or close the request.
    if (fail) begin
      if (!post_r) begin
        post_nxt = 1'b1; at_end_nxt = fin_r; app = 1'b1; app_b = cur_b_r;
        st_nxt = S_JUDGE;
        if (cnt_r == CW'(PENDING_DEPTH)) begin
          ovf_nxt = 1'b1; cons_k = 3'd1;
          act_b_nxt = pend_r[0]; act_trim_nxt = 1'b0; fidx_nxt = 2'd0;
          st_nxt = S_EMIT;
        end
      end else begin
        st_nxt = at_end_r ? S_FINAL : S_IDLE;
      end
    end

    cnt_nxt = cnt_r - CW'(cons_k) + CW'(app);
    if (st_r == S_FINAL && st_nxt == S_IDLE) cnt_nxt = '0;
  end

  // Window shift and append.
  always_ff @(posedge clk) begin
    for (int i = 0; i < PENDING_DEPTH; i++) begin
      if (app && CW'(i) == cnt_r - CW'(cons_k)) begin
        pend_r[i] <= app_b;
      end else if (i + int'(cons_k) < PENDING_DEPTH) begin
        pend_r[i] <= pend_r[IW'(i + int'(cons_k))];
      end
    end
    if (seq_we) seq_r[seq_wa] <= act_b_r;
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_b_r <= cur_b_nxt; fin_r <= fin_nxt; mode_r <= mode_nxt; x_r <= x_nxt;
    j_r <= j_nxt; act_b_r <= act_b_nxt; act_trim_r <= act_trim_nxt;
    tail_r <= tail_nxt; out_b_r <= out_b_nxt; out_l_r <= out_l_nxt;
    out_u_r <= out_u_nxt;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; post_r <= 1'b0; cnt_r <= '0; held_r <= 2'd0;
      tail_v_r <= 1'b0; rs0_r <= 8'h00; rs1_r <= 8'h00; em_r <= 2'd0;
      pass_r <= 2'd0; ovf_r <= 1'b0; at_end_r <= 1'b0; fidx_r <= 2'd0;
      out_v_r <= 1'b0;
    end else begin
      st_r <= st_nxt; post_r <= post_nxt; cnt_r <= cnt_nxt; held_r <= held_nxt;
      tail_v_r <= tail_v_nxt; rs0_r <= rs0_nxt; rs1_r <= rs1_nxt; em_r <= em_nxt;
      pass_r <= pass_nxt; ovf_r <= ovf_nxt; at_end_r <= at_end_nxt;
      fidx_r <= fidx_nxt; out_v_r <= out_v_nxt;
    end
  end

endmodule

@@ hdl/utf8_whitespace_normalizer.sv @@
// Channel | Direction | tdata          | tlast           | tuser
// in_     | slave     | [7:0] text_byte| is_final        | -
// out_    | master    | [7:0] out_byte | out_last        | [0] overflow
//
// A request sits in a two-entry queue; the engine then takes it into the window
// and makes one or more judgements at the window head.
// Look-ahead steps over control bytes one byte at a time.
// Reset is synchronous and active low; it empties the queue, window and output.
// Either side may stall at any time; the output register holds a result until taken.
module utf8_whitespace_normalizer
  import utf8wn_pkg::*;
#(
  parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,
  output logic       out_tuser   // [0] overflow
);

  logic    q_valid, q_ready;
  q_item_t q_item;

  // Request queue.
  utf8wn_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .q_valid, .q_ready, .q_item
  );

  // Normalising engine.
  utf8wn_engine #(.PENDING_DEPTH(PENDING_DEPTH)) u_engine (
    .clk, .rst_n, .q_valid, .q_ready, .q_item,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast, .out_tuser
  );

endmodule

@@ hdl/utf8wn_checker.sv @@
module utf8wn_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Reset leaves no result on the output.
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The queue is empty and ready straight after reset.
  a_rst_in: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind utf8_whitespace_normalizer utf8wn_checker u_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);

@@ tb/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: predicts the cleaned text from each accepted request and
  // compares the results of the block against it in order.
  class text_scoreboard;
    typedef struct {
      logic [7:0] data;
      logic       last;
      logic       ovf;
    } out_byte_t;

    out_byte_t  expected_q[$];
    int         errors;

    // Predictor state, one copy per message plus the window.
    logic [7:0] window_b[16];
    int         win_count;
    logic [7:0] hold_b[3];
    int         hold_count;
    logic [7:0] tail_b;
    bit         tail_ok;
    logic [7:0] solid_b[2];
    int         out_count;
    int         pass_left;
    bit         ovf_flag;
    bit         msg_end;

    function new();
      errors = 0;
      win_count = 0;
      msg_end = 0;
      foreach (window_b[i]) window_b[i] = 8'h00;
      clear_message();
    endfunction

    function void clear_message();
      foreach (hold_b[i]) hold_b[i] = 8'h00;
      hold_count = 0;
      tail_b = 8'h00;
      tail_ok = 0;
      solid_b[0] = 8'h00;
      solid_b[1] = 8'h00;
      out_count = 0;
      pass_left = 0;
      ovf_flag = 0;
    endfunction

    function bit is_ctl(logic [7:0] b);
      return (b < 8'h20 && b != 8'h0A) || b == 8'h7F;
    endfunction

    function logic [7:0] at(int p, int k);
      int i;
      i = p + k;
      return (i >= 0 && i < win_count) ? window_b[i] : 8'h00;
    endfunction

    function int lead_len(logic [7:0] b);
      if (b == 8'hC2 || b == 8'hCD) return 2;
      if (b == 8'hE1 || b == 8'hE2 || b == 8'hE3 || b == 8'hEF) return 3;
      return 1;
    endfunction

    // Bytes available from a position, or -1 while later input is still needed.
    function int avail_from(int p);
      int n;
      n = win_count - p;
      if (n < 0) n = 0;
      if (msg_end) return n;
      if (n == 0) return -1;
      return (n >= lead_len(at(p, 0))) ? n : -1;
    endfunction

    function int skip_ctl(int p);
      int j;
      j = p;
      while (j < win_count && is_ctl(window_b[j])) j++;
      if (j >= win_count && !msg_end) return -1;
      return j;
    endfunction

    function int len_invisible(int p, int n);
      logic [7:0] a, b, c;
      a = at(p, 0); b = at(p, 1); c = at(p, 2);
      if (n > 1 && a == 8'hCD && b == 8'h8F) return 2;
      if (n > 2 && ((a == 8'hE2 && b == 8'h80 && c >= 8'h8B && c <= 8'h8D) ||
                    (a == 8'hE2 && b == 8'h81 && c == 8'hA0) ||
                    (a == 8'hEF && b == 8'hBB && c == 8'hBF))) return 3;
      return 0;
    endfunction

    function int len_space(int p, int n);
      logic [7:0] a, b, c;
      a = at(p, 0); b = at(p, 1); c = at(p, 2);
      if (n > 0 && a == 8'h20) return 1;
      if (n > 1 && a == 8'hC2 && b == 8'hA0) return 2;
      if (n > 2 && ((a == 8'hE1 && b == 8'h9A && c == 8'h80) ||
                    (a == 8'hE2 && b == 8'h80 && c >= 8'h80 && c <= 8'h8A) ||
                    (a == 8'hE2 && b == 8'h80 && c == 8'hAF) ||
                    (a == 8'hE2 && b == 8'h81 && c == 8'h9F) ||
                    (a == 8'hE3 && b == 8'h80 && c >= 8'h80))) return 3;
      return 0;
    endfunction

    function int len_newline(int p, int n);
      logic [7:0] a, b, c;
      a = at(p, 0); b = at(p, 1); c = at(p, 2);
      if (n > 0 && a == 8'h0A) return 1;
      if (n > 1 && a == 8'hC2 && b == 8'h85) return 2;
      if (n > 2 && a == 8'hE2 && b == 8'h80 && (c == 8'hA8 || c == 8'hA9)) return 3;
      return 0;
    endfunction

    function void push_out(logic [7:0] b, bit last);
      out_byte_t e;
      e.data = b;
      e.last = last;
      e.ovf = ovf_flag;
      expected_q.push_back(e);
    endfunction

    function void flush_held();
      if (tail_ok) push_out(tail_b, 0);
      tail_ok = 0;
      for (int i = 0; i < hold_count; i++) push_out(hold_b[i], 0);
      hold_count = 0;
    endfunction

    function void send_out(logic [7:0] b, bit trim);
      if (out_count < 2) out_count++;
      if (!is_ctl(b)) begin
        solid_b[1] = solid_b[0];
        solid_b[0] = b;
      end
      if (trim) begin
        if (hold_count >= 3) flush_held();
        hold_b[hold_count++] = b;
      end else begin
        flush_held();
        tail_b = b;
        tail_ok = 1;
      end
    endfunction

    function void drop_head(int k);
      if (k > win_count) k = win_count;
      if (k <= 0) return;
      for (int i = 0; i + k < win_count; i++) window_b[i] = window_b[i + k];
      win_count -= k;
    endfunction

    // Decides the byte or character at the window head; 1 when progress was made.
    function bit judge_head();
      int n, x, o, n2, n3, y;
      bit drop;
      if (win_count == 0) return 0;
      if (pass_left > 0) begin
        send_out(window_b[0], 0);
        pass_left--;
        drop_head(1);
        return 1;
      end
      n = avail_from(0);
      if (n < 0) return 0;
      x = len_invisible(0, n);
      if (x > 0) begin
        o = skip_ctl(x);
        if (o < 0) return 0;
        n2 = avail_from(o);
        if (n2 < 0) return 0;
        if (len_space(o, n2) > 0 || len_newline(o, n2) > 0) begin
          drop_head(x);
          return 1;
        end
        n3 = avail_from(x);
        if (n3 < 0) return 0;
        y = len_invisible(x, n3);
        if (y > 0) begin
          drop_head(x + y);
          return 1;
        end
        pass_left = x - 1;
        send_out(window_b[0], 0);
        drop_head(1);
        return 1;
      end
      x = len_space(0, n);
      if (x > 0) begin
        drop = out_count == 0 || solid_b[0] == 8'h20 || solid_b[0] == 8'h0A;
        if (!drop) begin
          o = skip_ctl(x);
          if (o < 0) return 0;
          n2 = avail_from(o);
          if (n2 < 0) return 0;
          drop = len_newline(o, n2) > 0;
        end
        if (!drop) send_out(8'h20, 1);
        drop_head(x);
        return 1;
      end
      x = len_newline(0, n);
      if (x > 0) begin
        if (!(out_count < 2 || (solid_b[0] == 8'h0A && solid_b[1] == 8'h0A)))
          send_out(8'h0A, 1);
        drop_head(x);
        return 1;
      end
      send_out(window_b[0], 0);
      drop_head(1);
      return 1;
    endfunction

    // Notes one accepted request and queues the bytes that it releases.
    function void note_request(logic [7:0] b, bit last);
      msg_end = 0;
      if (win_count >= 16) begin
        while (judge_head()) ;
        if (win_count >= 16) begin
          ovf_flag = 1;
          send_out(window_b[0], 0);
          drop_head(1);
        end
      end
      window_b[win_count++] = b;
      msg_end = last;
      while (judge_head()) ;
      if (msg_end) begin
        win_count = 0;
        if (tail_ok) push_out(tail_b, 1);
        clear_message();
        msg_end = 0;
      end
    endfunction

    // Compares one result with the oldest expectation.
    function void check_result(logic [7:0] b, logic last, logic ovf);
      out_byte_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result data=%h last=%b ovf=%b", $time, b, last, ovf);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (e.data !== b || e.last !== last || e.ovf !== ovf) begin
        $display("%0t: mismatch expected data=%h last=%b ovf=%b, actual data=%h last=%b ovf=%b",
                 $time, e.data, e.last, e.ovf, b, last, ovf);
        errors++;
      end
    endfunction
  endclass

  typedef enum int {
    TK_LETTER, TK_ASCII_SP, TK_NBSP, TK_WIDE_SP, TK_NARROW_SP, TK_MATH_SP,
    TK_IDEO_SP, TK_OGHAM_SP, TK_LF, TK_NEL, TK_LINE_SEP, TK_CGJ, TK_ZW,
    TK_WJ, TK_BOM, TK_CTRL, TK_RANDOM, TK_BROKEN, TK_CTRL_RUN, TK_COUNT
  } token_e;

  localparam int LIMIT_CYCLES = 600000;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic       out_tuser;

  text_scoreboard text_sb;
  logic [7:0] msg_q[$];
  int         phase;
  int         sent_count;
  int         cycle_count;
  logic       hold_off;

  utf8_whitespace_normalizer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: checks each accepted result and stalls by phase and during the hold-off.
  always @(posedge clk) begin
    int pct;
    pct = (phase == 2) ? 58 : (phase == 3) ? 15 : 0;
    if (rst_n && out_tvalid && out_tready)
      text_sb.check_result(out_tdata, out_tlast, out_tuser);
    out_tready <= !hold_off && ($urandom_range(99) >= pct);
  end

  // Long hold-off on the result side so that the block fills up.
  initial begin
    hold_off <= 1'b0;
    wait (sent_count >= 150);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Appends one character of the chosen kind to the message.
  task automatic add_token(token_e k);
    int n;
    case (k)
      TK_LETTER:    msg_q.push_back(8'(8'h41 + $urandom_range(25)));
      TK_ASCII_SP:  msg_q.push_back(8'h20);
      TK_NBSP:      begin msg_q.push_back(8'hC2); msg_q.push_back(8'hA0); end
      TK_WIDE_SP:   begin
        msg_q.push_back(8'hE2); msg_q.push_back(8'h80);
        msg_q.push_back(8'(8'h80 + $urandom_range(10)));
      end
      TK_NARROW_SP: begin
        msg_q.push_back(8'hE2); msg_q.push_back(8'h80); msg_q.push_back(8'hAF);
      end
      TK_MATH_SP:   begin
        msg_q.push_back(8'hE2); msg_q.push_back(8'h81); msg_q.push_back(8'h9F);
      end
      TK_IDEO_SP:   begin
        msg_q.push_back(8'hE3); msg_q.push_back(8'h80);
        msg_q.push_back(8'(8'h80 + $urandom_range(127)));
      end
      TK_OGHAM_SP:  begin
        msg_q.push_back(8'hE1); msg_q.push_back(8'h9A); msg_q.push_back(8'h80);
      end
      TK_LF:        msg_q.push_back(8'h0A);
      TK_NEL:       begin msg_q.push_back(8'hC2); msg_q.push_back(8'h85); end
      TK_LINE_SEP:  begin
        msg_q.push_back(8'hE2); msg_q.push_back(8'h80);
        msg_q.push_back($urandom_range(1) ? 8'hA8 : 8'hA9);
      end
      TK_CGJ:       begin msg_q.push_back(8'hCD); msg_q.push_back(8'h8F); end
      TK_ZW:        begin
        msg_q.push_back(8'hE2); msg_q.push_back(8'h80);
        msg_q.push_back(8'(8'h8B + $urandom_range(2)));
      end
      TK_WJ:        begin
        msg_q.push_back(8'hE2); msg_q.push_back(8'h81); msg_q.push_back(8'hA0);
      end
      TK_BOM:       begin
        msg_q.push_back(8'hEF); msg_q.push_back(8'hBB); msg_q.push_back(8'hBF);
      end
      TK_CTRL:      msg_q.push_back($urandom_range(1) ? 8'h7F : 8'(8'h01 + $urandom_range(8)));
      TK_RANDOM:    msg_q.push_back(8'($urandom_range(255)));
      TK_BROKEN:    begin
        msg_q.push_back($urandom_range(1) ? 8'hE2 : 8'hC2);
        msg_q.push_back($urandom_range(1) ? 8'h80 : 8'h41);
      end
      default:      begin
        // A run of control bytes longer than the window.
        n = 17 + $urandom_range(4);
        repeat (n) msg_q.push_back($urandom_range(1) ? 8'h00 : 8'h1F);
      end
    endcase
  endtask

  // Offers one request and waits until it has been taken.
  task automatic send_byte(logic [7:0] b, logic last);
    int pct;
    in_tdata  <= b;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    text_sb.note_request(b, last);
    sent_count++;
    pct = (phase == 1) ? 58 : (phase == 3) ? 15 : 0;
    if ($urandom_range(99) < pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_q.size(); i++)
      send_byte(msg_q[i], i == msg_q.size() - 1);
    msg_q.delete();
  endtask

  initial begin
    int ntok;
    text_sb = new();
    sent_count = 0;
    phase = 0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 8'h00;
    in_tlast <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: leading space, byte extremes, several space and newline forms.
    add_token(TK_ASCII_SP); msg_q.push_back(8'h00); msg_q.push_back(8'hFF);
    add_token(TK_NBSP); add_token(TK_NEL); add_token(TK_LETTER);
    add_token(TK_OGHAM_SP); add_token(TK_LETTER); add_token(TK_NARROW_SP);
    add_token(TK_LF);
    send_message();
    // Invisible before a space, invisible pair, invisible kept, repeated newlines.
    add_token(TK_LETTER); add_token(TK_LETTER); add_token(TK_CGJ); add_token(TK_MATH_SP);
    add_token(TK_LETTER); add_token(TK_ZW); add_token(TK_WJ); add_token(TK_BOM);
    add_token(TK_LETTER); add_token(TK_LF); add_token(TK_LINE_SEP); add_token(TK_LF);
    add_token(TK_IDEO_SP);
    send_message();
    // Window overflow after a space, and a message with no output at all.
    add_token(TK_LETTER); add_token(TK_WIDE_SP); add_token(TK_CTRL_RUN);
    add_token(TK_LETTER);
    send_message();
    add_token(TK_ASCII_SP);
    send_message();

    // Random messages, mostly well formed; idling changes by phase.
    while (sent_count < 340) begin
      phase = (sent_count / 45) % 4;
      ntok = $urandom_range(1, 12);
      repeat (ntok) begin
        if ($urandom_range(99) < 85)
          add_token(token_e'($urandom_range(TK_LETTER, TK_BOM)));
        else
          add_token(token_e'($urandom_range(TK_CTRL, TK_COUNT - 1)));
      end
      send_message();
    end
    in_tvalid <= 1'b0;

    while (text_sb.expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (text_sb.errors == 0 && text_sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hdl/utf8wn_pkg.sv
hdl/utf8wn_front.sv
hdl/utf8wn_engine.sv
hdl/utf8_whitespace_normalizer.sv
hdl/utf8wn_checker.sv
tb/tb_top.sv
